// ===== rtl/xmad_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// xmad_pkg
// Shared types, codes and decode helpers for the MOV/ADD/SUB/CMP decoder.
// ----------------------------------------------------------------------------
package xmad_pkg;

	// instruction form codes; FORM_NONE marks a byte that starts no known form
	typedef enum logic [2:0] {
		FORM_RM_REG  = 3'd0,
		FORM_IMM_REG = 3'd1,
		FORM_IMM_RM  = 3'd2,
		FORM_ACC_MEM = 3'd3,
		FORM_IMM_ACC = 3'd4,
		FORM_NONE    = 3'd7
	} form_t;

	typedef enum logic [1:0] {
		OPER_MOV = 2'd0,
		OPER_ADD = 2'd1,
		OPER_SUB = 2'd2,
		OPER_CMP = 2'd3
	} oper_t;

	// group 80-83 reg field codes
	localparam logic [2:0] GRP_ADD = 3'b000;
	localparam logic [2:0] GRP_SUB = 3'b101;
	localparam logic [2:0] GRP_CMP = 3'b111;

	localparam logic [1:0] MOD_MEM    = 2'b00;
	localparam logic [1:0] MOD_DISP8  = 2'b01;
	localparam logic [1:0] MOD_DISP16 = 2'b10;
	localparam logic [1:0] MOD_REG    = 2'b11;
	localparam logic [2:0] RM_DIRECT  = 3'b110;
	localparam logic [2:0] REG_ACC    = 3'b000;

	// collected bytes of the current instruction
	typedef struct packed {
		logic [7:0]  opcode;
		logic [7:0]  modrm;
		logic [15:0] disp;
		logic [15:0] data;
		logic [2:0]  len;
	} xmad_inst_t;

	typedef struct packed {
		oper_t       operation;
		form_t       form;
		logic        wide;
		logic        to_register;
		logic [1:0]  addr_mode;
		logic [2:0]  reg_code;
		logic [2:0]  rm_code;
		logic [15:0] displacement;
		logic [15:0] immediate;
		logic        fault;
		logic [2:0]  length;
	} xmad_result_t;

	function automatic logic is_group(input logic [7:0] op);
		return op[7:2] == 6'b100000;
	endfunction

	function automatic form_t form_of(input logic [7:0] op);
		form_t f;
		f = FORM_NONE;
		if (op[7:2] == 6'b100010 || op[7:2] == 6'b000000)
			f = FORM_RM_REG;
		else if (op[7:4] == 4'b1011)
			f = FORM_IMM_REG;
		else if (op[7:1] == 7'b1100011 || is_group(op))
			f = FORM_IMM_RM;
		else if (op[7:2] == 6'b101000)
			f = FORM_ACC_MEM;
		else if (op[7:1] == 7'b0000010)
			f = FORM_IMM_ACC;
		return f;
	endfunction

	// number of immediate data bytes
	function automatic logic [1:0] data_count(input logic [7:0] op, input form_t f);
		logic [1:0] n;
		n = 2'd0;
		if (f == FORM_IMM_REG)
			n = op[3] ? 2'd2 : 2'd1;
		else if (f == FORM_IMM_RM && is_group(op))
			n = (op[1:0] == 2'b01) ? 2'd2 : 2'd1;
		else if (f == FORM_IMM_RM || f == FORM_IMM_ACC)
			n = op[0] ? 2'd2 : 2'd1;
		return n;
	endfunction

	// number of displacement bytes implied by mod-reg-rm
	function automatic logic [1:0] disp_count(input logic [7:0] modrm);
		logic [1:0] n;
		n = 2'd0;
		if (modrm[7:6] == MOD_DISP8)
			n = 2'd1;
		else if (modrm[7:6] == MOD_DISP16)
			n = 2'd2;
		else if (modrm[7:6] == MOD_MEM && modrm[2:0] == RM_DIRECT)
			n = 2'd2;
		return n;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/xmad_collect.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// xmad_collect
// Byte cursor and hold registers; flags the byte that completes an instruction.
// ----------------------------------------------------------------------------
module xmad_collect (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   fire,
	input  wire [7:0]             code_byte,
	output logic                  done,
	output xmad_pkg::xmad_inst_t  inst
);
	import xmad_pkg::*;

	logic [2:0]  idx_q, idx_n;
	xmad_inst_t  hold_q, hold_n;
	form_t       f;
	logic        adv;
	logic [2:0]  inc;
	logic [2:0]  p;
	logic [1:0]  nd;
	logic        put_disp;
	logic        k;
	logic [15:0] lane;

	always_comb begin
		hold_n   = hold_q;
		idx_n    = idx_q;
		done     = 1'b0;
		adv      = 1'b0;
		f        = FORM_NONE;
		p        = idx_q - 3'd2;
		nd       = disp_count(hold_q.modrm);
		put_disp = 1'b0;
		k        = 1'b0;
		lane     = 16'h0000;
		inc      = idx_q + 3'd1;
		if (fire) begin
			if (idx_q == 3'd0) begin
				f = form_of(code_byte);
				if (f != FORM_NONE) begin
					adv           = 1'b1;
					hold_n.opcode = code_byte;
					hold_n.modrm  = 8'h00;
					hold_n.disp   = 16'h0000;
					hold_n.data   = 16'h0000;
					if (f == FORM_RM_REG || f == FORM_IMM_RM)
						hold_n.len = 3'd2;
					else if (f == FORM_ACC_MEM)
						hold_n.len = 3'd3;
					else
						hold_n.len = 3'd1 + {1'b0, data_count(code_byte, f)};
				end
			end else begin
				adv = 1'b1;
				f   = form_of(hold_q.opcode);
				if (f == FORM_RM_REG || f == FORM_IMM_RM) begin
					if (idx_q == 3'd1) begin
						hold_n.modrm = code_byte;
						hold_n.len   = 3'd2 + {1'b0, disp_count(code_byte)}
							+ {1'b0, data_count(hold_q.opcode, f)};
					end else begin
						put_disp = p < {1'b0, nd};
						k        = put_disp ? p[0] : (p[0] ^ nd[0]);
					end
				end else begin
					put_disp = (f == FORM_ACC_MEM);
					k        = ~idx_q[0];
				end
				lane = k ? {code_byte, 8'h00} : {8'h00, code_byte};
				// the mod-reg-rm byte itself goes to neither hold
				if (!((f == FORM_RM_REG || f == FORM_IMM_RM) && idx_q == 3'd1)) begin
					if (put_disp)
						hold_n.disp = hold_q.disp | lane;
					else
						hold_n.data = hold_q.data | lane;
				end
			end
			if (adv) begin
				if (inc >= hold_n.len) begin
					done  = 1'b1;
					idx_n = 3'd0;
				end else begin
					idx_n = inc;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= 3'd0;
			hold_q <= '0;
		end else begin
			idx_q  <= idx_n;
			hold_q <= hold_n;
		end
	end

	assign inst = hold_n;

endmodule
`default_nettype wire

// ===== rtl/xmad_format.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// xmad_format
// Turns the collected bytes of one instruction into the decoded result.
// ----------------------------------------------------------------------------
module xmad_format (
	input  xmad_pkg::xmad_inst_t   inst,
	output xmad_pkg::xmad_result_t res
);
	import xmad_pkg::*;

	form_t      f;
	logic [1:0] nd;
	logic [1:0] ndisp;

	always_comb begin
		f     = form_of(inst.opcode);
		nd    = data_count(inst.opcode, f);
		ndisp = disp_count(inst.modrm);

		res              = '0;
		res.operation    = OPER_MOV;
		res.form         = f;
		res.wide         = (f == FORM_IMM_REG) ? inst.opcode[3] : inst.opcode[0];
		res.to_register  = 1'b1;
		res.addr_mode    = MOD_REG;
		res.reg_code     = REG_ACC;
		res.rm_code      = 3'd0;
		res.displacement = 16'h0000;
		res.fault        = 1'b0;
		res.length       = inst.len;

		unique case (f)
			FORM_RM_REG, FORM_IMM_RM: begin
				res.addr_mode = inst.modrm[7:6];
				res.reg_code  = inst.modrm[5:3];
				res.rm_code   = inst.modrm[2:0];
				if (ndisp == 2'd1)
					res.displacement = {{8{inst.disp[7]}}, inst.disp[7:0]};
				else if (ndisp == 2'd2)
					res.displacement = inst.disp;
				if (f == FORM_RM_REG) begin
					res.operation   = (inst.opcode[7:2] == 6'b000000) ? OPER_ADD : OPER_MOV;
					res.to_register = inst.opcode[1];
				end else begin
					res.to_register = (inst.modrm[7:6] == MOD_REG);
					if (is_group(inst.opcode)) begin
						if (inst.modrm[5:3] == GRP_ADD)
							res.operation = OPER_ADD;
						else if (inst.modrm[5:3] == GRP_SUB)
							res.operation = OPER_SUB;
						else if (inst.modrm[5:3] == GRP_CMP)
							res.operation = OPER_CMP;
						else
							res.fault = 1'b1;
					end
				end
			end
			FORM_IMM_REG: res.reg_code = inst.opcode[2:0];
			FORM_ACC_MEM: begin
				res.to_register  = ~inst.opcode[1];
				res.addr_mode    = MOD_MEM;
				res.rm_code      = RM_DIRECT;
				res.displacement = inst.disp;
			end
			default: res.operation = OPER_ADD;
		endcase

		if (nd == 2'd2)
			res.immediate = inst.data;
		else if (nd == 2'd1) begin
			if (inst.opcode[7:1] == 7'b1000001)
				res.immediate = {{8{inst.data[7]}}, inst.data[7:0]};
			else
				res.immediate = {8'h00, inst.data[7:0]};
		end else
			res.immediate = 16'h0000;
	end

endmodule
`default_nettype wire

// ===== rtl/x86_16bit_mov_add_decoder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// x86_16bit_mov_add_decoder
// 8086 MOV/ADD/SUB/CMP decoder fed one code byte per request.
// ----------------------------------------------------------------------------
//  channel   handshake                    payload
//  --------  ---------------------------  -------------------------------------
//  code      code_valid / code_ready      code_byte
//  result    result_valid / result_ready  operation form wide to_register
//                                         addr_mode reg_code rm_code
//                                         displacement immediate fault length
//
//  One byte per clock while no waiting result stalls it. A byte is
//  registered (_s1), then the cursor/hold logic and the result formatter
//  run combinationally into the result register, which then holds the
//  result of an instruction's last byte. Only the result register's slot gates
//  the flow: ready drops only while a result waits and result_ready is low.
//  Reset clears the cursor, valids and holds; no clearing pass.
// ----------------------------------------------------------------------------
module x86_16bit_mov_add_decoder (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         code_valid,
	output logic        code_ready,
	input  wire  [7:0]  code_byte,
	output logic        result_valid,
	input  wire         result_ready,
	output logic [1:0]  operation,
	output logic [2:0]  form,
	output logic        wide,
	output logic        to_register,
	output logic [1:0]  addr_mode,
	output logic [2:0]  reg_code,
	output logic [2:0]  rm_code,
	output logic [15:0] displacement,
	output logic [15:0] immediate,
	output logic        fault,
	output logic [2:0]  length
);
	import xmad_pkg::*;

	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         out_free;
	logic         fire;
	logic         done;
	xmad_inst_t   inst;
	xmad_result_t res;
	xmad_result_t res_q;
	logic         res_valid_q;

	// result slot free when empty or being taken this cycle
	assign out_free   = ~res_valid_q | result_ready;
	assign code_ready = ~valid_s1 | out_free;
	// byte in the input register is consumed this cycle
	assign fire       = valid_s1 & out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (code_ready) begin
			valid_s1 <= code_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (code_ready && code_valid)
			byte_s1 <= code_byte;
	end

	xmad_collect u_collect (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.code_byte (byte_s1),
		.done      (done),
		.inst      (inst)
	);

	xmad_format u_format (
		.inst (inst),
		.res  (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_free) begin
			res_valid_q <= fire & done;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && done)
			res_q <= res;
	end

	assign result_valid = res_valid_q;
	assign operation    = res_q.operation;
	assign form         = res_q.form;
	assign wide         = res_q.wide;
	assign to_register  = res_q.to_register;
	assign addr_mode    = res_q.addr_mode;
	assign reg_code     = res_q.reg_code;
	assign rm_code      = res_q.rm_code;
	assign displacement = res_q.displacement;
	assign immediate    = res_q.immediate;
	assign fault        = res_q.fault;
	assign length       = res_q.length;

endmodule
`default_nettype wire

// ===== rtl/xmad_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// xmad_checker
// Port-level checks for the decoder, bound to the top level.
// ----------------------------------------------------------------------------
module xmad_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        result_valid,
	input wire        result_ready,
	input wire [1:0]  operation,
	input wire [2:0]  form,
	input wire        wide,
	input wire        to_register,
	input wire [1:0]  addr_mode,
	input wire [2:0]  reg_code,
	input wire [2:0]  rm_code,
	input wire [15:0] displacement,
	input wire [15:0] immediate,
	input wire        fault,
	input wire [2:0]  length
);
	import xmad_pkg::*;

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid
		&& $stable({operation, form, wide, to_register, addr_mode, reg_code,
			rm_code, displacement, immediate, fault, length}))
		else $error("stalled result changed");

	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> length >= 3'd2 && length <= 3'd6)
		else $error("length out of range");

	a_fault: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && fault |-> form == FORM_IMM_RM && operation == OPER_MOV)
		else $error("fault outside group form");

	a_imm_reg: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (form == FORM_IMM_REG || form == FORM_IMM_ACC)
		|-> addr_mode == MOD_REG && to_register && rm_code == 3'd0)
		else $error("register form fields wrong");

	a_no_result_data: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (form == FORM_RM_REG || form == FORM_ACC_MEM)
		|-> immediate == 16'h0000)
		else $error("immediate set on form without data");

endmodule

bind x86_16bit_mov_add_decoder xmad_checker u_xmad_checker (.*);
`default_nettype wire

// ===== dv/x86_16bit_mov_add_decoder_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// x86_16bit_mov_add_decoder_test
// Self-checking bench for the MOV/ADD/SUB/CMP byte-stream decoder. A small
// scoreboard tracks the decode cursor byte by byte, queues the instruction
// each last byte should yield and checks every returned request field by
// field. Directed bytes first, then random well-formed instructions mixed
// with noise, under four sender/receiver idling phases.
// ----------------------------------------------------------------------------

import xmad_pkg::*;

class decode_scoreboard;
	// mirror of the decode cursor and the collected bytes
	logic [2:0]   cursor;
	logic [7:0]   op_byte;
	logic [7:0]   modrm_byte;
	logic [15:0]  disp_bytes_got;
	logic [15:0]  data_bytes_got;
	logic [2:0]   needed;
	xmad_result_t expected_insts[$];
	int           errors;
	int           bytes_seen;
	int           skipped;
	int           checked;
	int           faults;

	function new();
		cursor = '0;
		op_byte = '0;
		modrm_byte = '0;
		disp_bytes_got = '0;
		data_bytes_got = '0;
		needed = '0;
		errors = 0;
		bytes_seen = 0;
		skipped = 0;
		checked = 0;
		faults = 0;
	endfunction

	static function form_t kind_of(input logic [7:0] b);
		if (b[7:2] == 6'b100010 || b[7:2] == 6'b000000)
			return FORM_RM_REG;
		if (b[7:4] == 4'hB)
			return FORM_IMM_REG;
		if (b[7:1] == 7'b1100011 || b[7:2] == 6'b100000)
			return FORM_IMM_RM;
		if (b[7:2] == 6'b101000)
			return FORM_ACC_MEM;
		if (b[7:1] == 7'b0000010)
			return FORM_IMM_ACC;
		return FORM_NONE;
	endfunction

	static function int imm_bytes(input logic [7:0] b, input form_t f);
		case (f)
			FORM_IMM_REG: return b[3] ? 2 : 1;
			FORM_IMM_RM: begin
				if (b[7:2] == 6'b100000)
					return (b[1:0] == 2'b01) ? 2 : 1;
				return b[0] ? 2 : 1;
			end
			FORM_IMM_ACC: return b[0] ? 2 : 1;
			default: return 0;
		endcase
	endfunction

	static function int disp_bytes(input logic [7:0] m);
		case (m[7:6])
			MOD_DISP8: return 1;
			MOD_DISP16: return 2;
			MOD_MEM: return (m[2:0] == RM_DIRECT) ? 2 : 0;
			default: return 0;
		endcase
	endfunction

	// instruction the collected bytes stand for
	function xmad_result_t decoded();
		xmad_result_t r;
		form_t f;
		int n;
		f = kind_of(op_byte);
		r = '0;
		r.form = f;
		r.operation = OPER_MOV;
		r.to_register = 1'b1;
		r.addr_mode = MOD_REG;
		r.reg_code = REG_ACC;
		r.length = needed;
		r.wide = (f == FORM_IMM_REG) ? op_byte[3] : op_byte[0];
		case (f)
			FORM_RM_REG, FORM_IMM_RM: begin
				r.addr_mode = modrm_byte[7:6];
				r.reg_code = modrm_byte[5:3];
				r.rm_code = modrm_byte[2:0];
				n = disp_bytes(modrm_byte);
				if (n == 1)
					r.displacement = {{8{disp_bytes_got[7]}}, disp_bytes_got[7:0]};
				else if (n == 2)
					r.displacement = disp_bytes_got;
				if (f == FORM_RM_REG) begin
					r.operation = (op_byte[7:2] == 6'b000000) ? OPER_ADD : OPER_MOV;
					r.to_register = op_byte[1];
				end else begin
					r.to_register = (modrm_byte[7:6] == MOD_REG);
					if (op_byte[7:2] == 6'b100000) begin
						case (modrm_byte[5:3])
							GRP_ADD: r.operation = OPER_ADD;
							GRP_SUB: r.operation = OPER_SUB;
							GRP_CMP: r.operation = OPER_CMP;
							default: r.fault = 1'b1;
						endcase
					end
				end
			end
			FORM_IMM_REG: r.reg_code = op_byte[2:0];
			FORM_ACC_MEM: begin
				r.to_register = ~op_byte[1];
				r.addr_mode = MOD_MEM;
				r.rm_code = RM_DIRECT;
				r.displacement = disp_bytes_got;
			end
			default: r.operation = OPER_ADD;
		endcase
		n = imm_bytes(op_byte, f);
		if (n == 2)
			r.immediate = data_bytes_got;
		else if (n == 1)
			// s=1 group forms sign-extend a single data byte
			r.immediate = (op_byte[7:1] == 7'b1000001 && data_bytes_got[7]) ?
				{8'hFF, data_bytes_got[7:0]} : {8'h00, data_bytes_got[7:0]};
		if (r.fault)
			faults++;
		return r;
	endfunction

	// one accepted code byte
	function void note_byte(input logic [7:0] b);
		form_t f;
		int p;
		int nd;
		bytes_seen++;
		if (cursor == 3'd0) begin
			f = kind_of(b);
			if (f == FORM_NONE) begin
				skipped++;
				return;
			end
			op_byte = b;
			modrm_byte = '0;
			disp_bytes_got = '0;
			data_bytes_got = '0;
			if (f == FORM_RM_REG || f == FORM_IMM_RM)
				needed = 3'd2;
			else if (f == FORM_ACC_MEM)
				needed = 3'd3;
			else
				needed = 3'(1 + imm_bytes(b, f));
		end else begin
			f = kind_of(op_byte);
			if (f == FORM_RM_REG || f == FORM_IMM_RM) begin
				if (cursor == 3'd1) begin
					modrm_byte = b;
					needed = 3'(2 + disp_bytes(b) + imm_bytes(op_byte, f));
				end else begin
					p = int'(cursor) - 2;
					nd = disp_bytes(modrm_byte);
					if (p < nd)
						disp_bytes_got = disp_bytes_got | ({8'h00, b} << (8 * (p % 2)));
					else
						data_bytes_got = data_bytes_got | ({8'h00, b} << (8 * ((p - nd) % 2)));
				end
			end else if (f == FORM_ACC_MEM) begin
				p = int'(cursor) - 1;
				disp_bytes_got = disp_bytes_got | ({8'h00, b} << (8 * (p % 2)));
			end else begin
				p = int'(cursor) - 1;
				data_bytes_got = data_bytes_got | ({8'h00, b} << (8 * (p % 2)));
			end
		end
		cursor = cursor + 3'd1;
		if (cursor >= needed) begin
			expected_insts.push_back(decoded());
			cursor = 3'd0;
		end
	endfunction

	task report(input string msg);
		$display("ERROR at %0t: %s", $time, msg);
		errors++;
	endtask

	task check_field(input string name, input int got, input int want);
		if (got != want)
			report($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	// one accepted result request
	task check(input xmad_result_t got);
		xmad_result_t want;
		checked++;
		if (expected_insts.size() == 0) begin
			report($sformatf("unexpected result: form %0d length %0d", got.form, got.length));
			return;
		end
		want = expected_insts.pop_front();
		check_field("operation", got.operation, want.operation);
		check_field("form", got.form, want.form);
		check_field("wide", got.wide, want.wide);
		check_field("to_register", got.to_register, want.to_register);
		check_field("addr_mode", got.addr_mode, want.addr_mode);
		check_field("reg_code", got.reg_code, want.reg_code);
		check_field("rm_code", got.rm_code, want.rm_code);
		check_field("displacement", got.displacement, want.displacement);
		check_field("immediate", got.immediate, want.immediate);
		check_field("fault", got.fault, want.fault);
		check_field("length", got.length, want.length);
	endtask
endclass

module x86_16bit_mov_add_decoder_test;

	logic        clk;
	logic        arst_n;
	logic        code_valid;
	logic        code_ready;
	logic [7:0]  code_byte;
	logic        result_valid;
	logic        result_ready;
	logic [1:0]  operation;
	logic [2:0]  form;
	logic        wide;
	logic        to_register;
	logic [1:0]  addr_mode;
	logic [2:0]  reg_code;
	logic [2:0]  rm_code;
	logic [15:0] displacement;
	logic [15:0] immediate;
	logic        fault;
	logic [2:0]  length;

	// idling odds, in percent per cycle
	int send_idle_pct;
	int recv_stall_pct;

	decode_scoreboard sb = new();

	// directed stream: unknown opcode (skipped), all-zero ADD, negative disp8,
	// imm16 of all ones, store of AL/AX to a direct address, sign-extended
	// SUB immediate, CMP on a direct address, six-byte group with an
	// unsupported operation (fault), ADD immediate to accumulator
	localparam logic [7:0] DIRECTED [28] = '{
		8'hFF,
		8'h00, 8'h00,
		8'h8B, 8'h46, 8'h80,
		8'hB8, 8'hFF, 8'hFF,
		8'hA3, 8'h00, 8'h80,
		8'h83, 8'hE8, 8'h80,
		8'h80, 8'h3E, 8'h34, 8'h12, 8'hFF,
		8'h81, 8'h98, 8'hFF, 8'h7F, 8'h34, 8'h12,
		8'h04, 8'h7F
	};

	x86_16bit_mov_add_decoder dut (.*);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// receiver: random backpressure on the result channel
	always @(posedge clk) begin
		result_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// monitor: both channels sampled at the same edge, so the prediction for
	// a byte is always queued before its result can come back
	always @(posedge clk) begin
		if (arst_n) begin
			if (code_valid && code_ready)
				sb.note_byte(code_byte);
			if (result_valid && result_ready)
				sb.check(xmad_result_t'({operation, form, wide, to_register, addr_mode,
					reg_code, rm_code, displacement, immediate, fault, length}));
		end
	end

	// hard stop in case the handshake hangs
	initial begin
		#5_000_000;
		$display("FAILURE");
		$finish;
	end

	// one code request: optional idle cycles, then hold until accepted
	task send_byte(input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			code_valid <= 1'b0;
			@(posedge clk);
		end
		code_valid <= 1'b1;
		code_byte <= b;
		@(posedge clk);
		while (!code_ready)
			@(posedge clk);
	endtask

	// data/disp byte leaning toward the sign and range edges
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(7))
			0: return 8'h00;
			1: return 8'hFF;
			2: return 8'h7F;
			3: return 8'h80;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// well-formed instruction with random content; form chosen evenly
	task send_instruction();
		logic [7:0] op;
		logic [7:0] m;
		form_t f;
		int n;
		case ($urandom_range(4))
			0: op = {($urandom_range(1) ? 6'b100010 : 6'b000000), 2'($urandom_range(3))};
			1: op = {4'hB, 4'($urandom_range(15))};
			2: op = $urandom_range(1) ? {7'b1100011, 1'($urandom_range(1))} :
				{6'b100000, 2'($urandom_range(3))};
			3: op = {6'b101000, 2'($urandom_range(3))};
			default: op = {7'b0000010, 1'($urandom_range(1))};
		endcase
		send_byte(op);
		f = sb.kind_of(op);
		n = 0;
		if (f == FORM_RM_REG || f == FORM_IMM_RM) begin
			m = 8'($urandom_range(255));
			// direct address is a rare corner of mod 00, so push it
			if ($urandom_range(3) == 0)
				m = {MOD_MEM, m[5:3], RM_DIRECT};
			send_byte(m);
			n = sb.disp_bytes(m);
		end else if (f == FORM_ACC_MEM) begin
			n = 2;
		end
		n += sb.imm_bytes(op, f);
		repeat (n)
			send_byte(pick_byte());
	endtask

	// stop sending and wait until every predicted instruction came back
	task drain();
		code_valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_insts.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		code_valid <= 1'b0;
		code_byte <= 8'h00;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i])
			send_byte(DIRECTED[i]);
		drain();

		// phases: free-running, sender idle, receiver stalled, both
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
				default: begin send_idle_pct = 25; recv_stall_pct = 25; end
			endcase
			repeat (140) begin
				// mostly clean instructions; noise may start or cut one short
				if ($urandom_range(9) == 0)
					repeat ($urandom_range(3, 1))
						send_byte(8'($urandom_range(255)));
				else
					send_instruction();
			end
			drain();
		end

		// the result path holds an input and a result register; give it room for strays
		repeat (10) @(posedge clk);
		if (sb.expected_insts.size() != 0)
			sb.report($sformatf("%0d instructions never returned", sb.expected_insts.size()));

		$display("Fed %0d code bytes (%0d skipped as unknown opcodes) and checked %0d results,",
			sb.bytes_seen, sb.skipped, sb.checked);
		$display("%0d of them group faults, over four sender/receiver idling phases.",
			sb.faults);
		if (sb.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
